[hw/rtl/est_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// est_pkg: shared types and constants of the event subscription table
// Opcodes, event ID codes, slot memory word layout and sequencer states.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned SND_W  = 16;
  localparam int unsigned PCNT_W = 5;

  localparam logic [ID_W-1:0] DELETED_ID = 8'd0;
  localparam logic [ID_W-1:0] LOS_ID     = 8'd1;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER    = 3'd0,
    OP_REMOVE      = 3'd1,
    OP_POST        = 3'd2,
    OP_CHECK_CLEAR = 3'd3,
    OP_CLEAR_ALL   = 3'd4,
    OP_QUERY       = 3'd5,
    OP_IS_REG      = 3'd6
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]  ev_id;
    logic             pend;
    logic             sok;
    logic [SND_W-1:0] sender;
  } slot_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_TEST,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/est_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// est_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module est_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/event_subscription_table_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// event_subscription_table_top: per-object event subscription table
// Commands arrive on the in_ channel (opcode, event ID, sender ID); each
// command gives exactly one result beat on the out_ channel with hit flags,
// the stored last sender, the pending count and the generic pending flag.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. Slots live in one slot memory with a registered read port, which
// is scanned one slot at a time from slot 0 upwards, through a read state
// and a test state per slot. A scan covers up to the slots in use, or
// SLOTS for clear-all; an unused opcode or a register of ID 0 skips the
// scan. One command is in work at a time; a new command is taken once
// the previous result sits in the output register, even if that result
// is still stalled.
// After reset a clearing pass writes every slot of the slot memory, with
// line-of-sight in slot 0; in_stall stays high during that pass.
// A stalled result holds in the output register; a finished command waits
// for it to drain before its own result is loaded.
// ----------------------------------------------------------------------------
module event_subscription_table_top #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [est_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [est_pkg::ID_W-1:0]   in_event_id,
  input  wire logic [est_pkg::SND_W-1:0]  in_sender_id,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic                       out_hit,
  output      logic [est_pkg::SND_W-1:0]  out_last_sender,
  output      logic                       out_sender_valid,
  output      logic                       out_sender_match,
  output      logic [est_pkg::PCNT_W-1:0] out_pending_count,
  output      logic                       out_generic_pending,
  output      logic                       out_table_full
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned UW = $clog2(SLOTS + 1);
  localparam int unsigned SW = $bits(est_pkg::slot_t);

  est_pkg::state_t                state_r, state_nxt;
  logic [IW-1:0]                  idx_r, idx_nxt;
  logic [UW-1:0]                  used_r, used_nxt;
  logic [UW-1:0]                  cnt_r, cnt_nxt;
  logic                           gen_r, gen_nxt;
  est_pkg::op_t                   op_r, op_nxt;
  logic [est_pkg::ID_W-1:0]       id_r, id_nxt;
  logic [est_pkg::SND_W-1:0]      snd_r, snd_nxt;
  logic                           hit_r, hit_nxt;
  logic [est_pkg::SND_W-1:0]      last_r, last_nxt;
  logic                           sval_r, sval_nxt;
  logic                           smatch_r, smatch_nxt;
  logic                           full_r, full_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_hit_r;
  logic [est_pkg::SND_W-1:0]      out_last_r;
  logic                           out_sval_r;
  logic                           out_smatch_r;
  logic [est_pkg::PCNT_W-1:0]     out_cnt_r;
  logic                           out_gen_r;
  logic                           out_full_r;

  logic                           we;
  logic [IW-1:0]                  waddr;
  est_pkg::slot_t                 wdata;
  logic [SW-1:0]                  rd_bits;
  est_pkg::slot_t                 rd;

  logic                           accept;
  logic                           skip;
  logic                           drop;
  logic [UW-1:0]                  cnt_dec;
  logic [UW-1:0]                  cnt_eff;
  logic                           pend_eff;
  logic                           idmatch;
  logic                           found;
  logic                           last_slot;
  logic                           init_last;
  logic                           out_free;

  est_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rd_bits)
  );

  assign rd        = est_pkg::slot_t'(rd_bits);
  assign in_stall  = (state_r != est_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign init_last = (idx_r == IW'(SLOTS - 1));
  assign out_free  = !out_valid_r || !out_stall;

  // decode of a new command
  always_comb begin
    unique case (in_opcode) inside
      est_pkg::OP_REGISTER: skip = (in_event_id == est_pkg::DELETED_ID);
      est_pkg::OP_REMOVE, est_pkg::OP_POST, est_pkg::OP_CHECK_CLEAR,
      est_pkg::OP_CLEAR_ALL, est_pkg::OP_QUERY, est_pkg::OP_IS_REG: skip = 1'b0;
      default: skip = 1'b1;
    endcase
  end

  // slot test
  always_comb begin
    drop     = (op_r == est_pkg::OP_CHECK_CLEAR) && (idx_r == '0) &&
               (id_r != est_pkg::LOS_ID) && rd.pend;
    cnt_dec  = (cnt_r != '0) ? cnt_r - UW'(1) : '0;
    cnt_eff  = drop ? cnt_dec : cnt_r;
    pend_eff = rd.pend && !drop;
    idmatch  = (rd.ev_id == id_r);
    unique case (op_r) inside
      est_pkg::OP_REGISTER:
        found = (rd.ev_id == est_pkg::DELETED_ID) || idmatch;
      est_pkg::OP_REMOVE, est_pkg::OP_POST, est_pkg::OP_QUERY, est_pkg::OP_IS_REG:
        found = (id_r != est_pkg::DELETED_ID) && idmatch;
      est_pkg::OP_CHECK_CLEAR:
        found = (id_r != est_pkg::DELETED_ID) && idmatch && pend_eff && (cnt_eff != '0);
      default: found = 1'b0;
    endcase
    if (op_r == est_pkg::OP_CLEAR_ALL) begin
      last_slot = init_last;
    end else begin
      last_slot = (UW'(idx_r) + UW'(1) == used_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      est_pkg::ST_INIT: if (init_last) state_nxt = est_pkg::ST_IDLE;
      est_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = skip ? est_pkg::ST_DONE : est_pkg::ST_RD;
        end
      end
      est_pkg::ST_RD:   state_nxt = est_pkg::ST_TEST;
      est_pkg::ST_TEST: begin
        if (found || last_slot) begin
          state_nxt = est_pkg::ST_DONE;
        end else begin
          state_nxt = est_pkg::ST_RD;
        end
      end
      est_pkg::ST_DONE: if (out_free) state_nxt = est_pkg::ST_IDLE;
      default:          state_nxt = est_pkg::ST_INIT;
    endcase
  end

  // datapath and memory write
  always_comb begin
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = rd;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    gen_nxt       = gen_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    snd_nxt       = snd_r;
    hit_nxt       = hit_r;
    last_nxt      = last_r;
    sval_nxt      = sval_r;
    smatch_nxt    = smatch_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      est_pkg::ST_INIT: begin
        we          = 1'b1;
        wdata       = '0;
        wdata.ev_id = (idx_r == '0) ? est_pkg::LOS_ID : est_pkg::DELETED_ID;
        idx_nxt     = init_last ? '0 : idx_r + IW'(1);
      end
      est_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt     = est_pkg::op_t'(in_opcode);
          id_nxt     = in_event_id;
          snd_nxt    = in_sender_id;
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
          last_nxt   = '0;
          sval_nxt   = 1'b0;
          smatch_nxt = 1'b0;
          full_nxt   = 1'b0;
          if (in_opcode == est_pkg::OP_CLEAR_ALL) begin
            cnt_nxt = '0;
            gen_nxt = 1'b0;
          end
        end
      end
      est_pkg::ST_RD: begin
      end
      est_pkg::ST_TEST: begin
        idx_nxt = idx_r + IW'(1);
        if (drop) begin
          we         = 1'b1;
          wdata.pend = 1'b0;
          cnt_nxt    = cnt_dec;
        end
        if (op_r == est_pkg::OP_CLEAR_ALL) begin
          we         = 1'b1;
          wdata.pend = 1'b0;
        end
        if (found) begin
          unique case (op_r) inside
            est_pkg::OP_REGISTER: begin
              if (!idmatch) begin
                we          = 1'b1;
                wdata.ev_id = id_r;
                wdata.pend  = 1'b0;
                wdata.sok   = 1'b0;
              end
            end
            est_pkg::OP_REMOVE: begin
              we          = 1'b1;
              wdata.ev_id = est_pkg::DELETED_ID;
              wdata.pend  = 1'b0;
              wdata.sok   = 1'b0;
              if (rd.pend) cnt_nxt = cnt_dec;
            end
            est_pkg::OP_POST: begin
              we           = 1'b1;
              wdata.pend   = 1'b1;
              wdata.sok    = 1'b1;
              wdata.sender = snd_r;
              if (!rd.pend) cnt_nxt = cnt_r + UW'(1);
              gen_nxt      = 1'b1;
              hit_nxt      = 1'b1;
            end
            est_pkg::OP_CHECK_CLEAR: begin
              we         = 1'b1;
              wdata.pend = 1'b0;
              cnt_nxt    = cnt_dec;
              gen_nxt    = (cnt_dec != '0);
              hit_nxt    = 1'b1;
            end
            est_pkg::OP_QUERY: begin
              hit_nxt = 1'b1;
              if (rd.sok) begin
                sval_nxt   = 1'b1;
                last_nxt   = rd.sender;
                smatch_nxt = (rd.sender == snd_r);
              end
            end
            est_pkg::OP_IS_REG: hit_nxt = 1'b1;
            default: begin
            end
          endcase
        end else if (last_slot && (op_r == est_pkg::OP_REGISTER)) begin
          // grow the table by one slot, or flag it full
          if (used_r == UW'(SLOTS)) begin
            full_nxt = 1'b1;
          end else begin
            we          = 1'b1;
            waddr       = used_r[IW-1:0];
            wdata       = '0;
            wdata.ev_id = id_r;
            used_nxt    = used_r + UW'(1);
          end
        end
      end
      est_pkg::ST_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= est_pkg::ST_INIT;
      idx_r       <= '0;
      used_r      <= UW'(1);
      cnt_r       <= '0;
      gen_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    snd_r    <= snd_nxt;
    hit_r    <= hit_nxt;
    last_r   <= last_nxt;
    sval_r   <= sval_nxt;
    smatch_r <= smatch_nxt;
    full_r   <= full_nxt;
    if ((state_r == est_pkg::ST_DONE) && out_free) begin
      out_hit_r    <= hit_r;
      out_last_r   <= last_r;
      out_sval_r   <= sval_r;
      out_smatch_r <= smatch_r;
      out_cnt_r    <= est_pkg::PCNT_W'(cnt_r);
      out_gen_r    <= gen_r;
      out_full_r   <= full_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_last_sender     = out_last_r;
  assign out_sender_valid    = out_sval_r;
  assign out_sender_match    = out_smatch_r;
  assign out_pending_count   = out_cnt_r;
  assign out_generic_pending = out_gen_r;
  assign out_table_full      = out_full_r;

endmodule
`default_nettype wire

[bench/subscription_checker.sv]
// ----------------------------------------------------------------------------
// subscription_checker: result predictor and comparator for the event table
// Watches both channels of the event subscription table. Each accepted
// command beat updates a private copy of the slot table and queues the
// result it must give; each accepted result beat is compared field by field
// with the oldest queued result. Mismatches and stray results are counted.
// ----------------------------------------------------------------------------
module subscription_checker
  import est_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [ID_W-1:0]   in_event_id,
  input  logic [SND_W-1:0]  in_sender_id,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_hit,
  input  logic [SND_W-1:0]  out_last_sender,
  input  logic              out_sender_valid,
  input  logic              out_sender_match,
  input  logic [PCNT_W-1:0] out_pending_count,
  input  logic              out_generic_pending,
  input  logic              out_table_full,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    logic              hit;
    logic [SND_W-1:0]  last_sender;
    logic              sender_valid;
    logic              sender_match;
    logic [PCNT_W-1:0] pending_count;
    logic              generic_pending;
    logic              table_full;
  } table_result_t;

  logic [ID_W-1:0]  sub_id          [SLOTS];
  logic             sub_pend        [SLOTS];
  logic [SND_W-1:0] sub_sender      [SLOTS];
  logic             sub_sender_seen [SLOTS];
  int unsigned      slots_in_use;
  int unsigned      pend_count;
  logic             generic_seen;
  int               errors = 0;
  table_result_t    expected_results [$];

  function automatic int unsigned lookup_slot(input logic [ID_W-1:0] id);
    if (id == DELETED_ID) return slots_in_use;
    for (int unsigned k = 0; k < slots_in_use; k++)
      if (sub_id[k] == id) return k;
    return slots_in_use;
  endfunction

  task automatic dec_pending();
    if (pend_count > 0) pend_count--;
  endtask

  task automatic apply_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                               input logic [SND_W-1:0] snd, output table_result_t res);
    int unsigned i;
    logic        found;
    res = '0;
    case (op)
      OP_REGISTER: begin
        if (id != DELETED_ID) begin
          i = 0;
          while (i < slots_in_use && sub_id[i] != DELETED_ID && sub_id[i] != id) i++;
          if (i >= slots_in_use && slots_in_use >= SLOTS) begin
            res.table_full = 1'b1;
          end else begin
            if (i >= slots_in_use) slots_in_use++;
            if (sub_id[i] != id) begin
              sub_id[i]          = id;
              sub_pend[i]        = 1'b0;
              sub_sender_seen[i] = 1'b0;
            end
          end
        end
      end
      OP_REMOVE: begin
        i = lookup_slot(id);
        if (i < slots_in_use) begin
          sub_id[i]          = DELETED_ID;
          sub_sender_seen[i] = 1'b0;
          if (sub_pend[i]) begin
            sub_pend[i] = 1'b0;
            dec_pending();
          end
        end
      end
      OP_POST: begin
        i = lookup_slot(id);
        if (i < slots_in_use) begin
          if (!sub_pend[i]) begin
            sub_pend[i] = 1'b1;
            pend_count++;
          end
          sub_sender[i]      = snd;
          sub_sender_seen[i] = 1'b1;
          generic_seen       = 1'b1;
          res.hit            = 1'b1;
        end
      end
      OP_CHECK_CLEAR: begin
        // drop a line-of-sight pending bit on any other check
        if (id != LOS_ID && sub_pend[0]) begin
          sub_pend[0] = 1'b0;
          dec_pending();
        end
        if (pend_count != 0 && id != DELETED_ID) begin
          found = 1'b0;
          for (i = 0; i < slots_in_use && !found; i++) begin
            if (sub_id[i] == id && sub_pend[i]) begin
              sub_pend[i]  = 1'b0;
              dec_pending();
              generic_seen = (pend_count != 0);
              res.hit      = 1'b1;
              found        = 1'b1;
            end
          end
        end
      end
      OP_CLEAR_ALL: begin
        generic_seen = 1'b0;
        pend_count   = 0;
        for (int k = 0; k < SLOTS; k++) sub_pend[k] = 1'b0;
      end
      OP_QUERY: begin
        i = lookup_slot(id);
        if (i < slots_in_use) begin
          res.hit = 1'b1;
          if (sub_sender_seen[i]) begin
            res.sender_valid = 1'b1;
            res.last_sender  = sub_sender[i];
            res.sender_match = (sub_sender[i] == snd);
          end
        end
      end
      OP_IS_REG: res.hit = (lookup_slot(id) < slots_in_use);
      default: ;
    endcase
    res.pending_count   = pend_count[PCNT_W-1:0];
    res.generic_pending = generic_seen;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    table_result_t want;
    table_result_t seen;
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) begin
        sub_id[k]          = DELETED_ID;
        sub_pend[k]        = 1'b0;
        sub_sender[k]      = '0;
        sub_sender_seen[k] = 1'b0;
      end
      sub_id[0]    = LOS_ID;
      slots_in_use = 1;
      pend_count   = 0;
      generic_seen = 1'b0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_opcode, in_event_id, in_sender_id, want);
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        seen.hit             = out_hit;
        seen.last_sender     = out_last_sender;
        seen.sender_valid    = out_sender_valid;
        seen.sender_match    = out_sender_match;
        seen.pending_count   = out_pending_count;
        seen.generic_pending = out_generic_pending;
        seen.table_full      = out_table_full;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with no command waiting: expected none, got hit %0b count %0d",
                   $time, seen.hit, seen.pending_count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(seen.hit));
          check_field("last_sender", 32'(want.last_sender), 32'(seen.last_sender));
          check_field("sender_valid", 32'(want.sender_valid), 32'(seen.sender_valid));
          check_field("sender_match", 32'(want.sender_match), 32'(seen.sender_match));
          check_field("pending_count", 32'(want.pending_count), 32'(seen.pending_count));
          check_field("generic_pending", 32'(want.generic_pending),
                      32'(seen.generic_pending));
          check_field("table_full", 32'(want.table_full), 32'(seen.table_full));
        end
      end
    end
    fail_count  <= errors;
    outstanding <= expected_results.size();
  end

endmodule

[bench/event_subscription_table_top_tb.sv]
// ----------------------------------------------------------------------------
// event_subscription_table_top_tb: testbench of the event subscription table
// Drives a directed opening of command beats over the ID extremes, every
// opcode and the line-of-sight corner cases, then random command streams
// drawn from small changing ID pools so that the table fills, overflows,
// reuses deleted slots and holds duplicates. Sender and receiver idle at
// random in several phases; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module event_subscription_table_top_tb;
  import est_pkg::*;

  localparam int unsigned   SLOTS        = 16;
  localparam int            RANDOM_ITEMS = 1100;
  localparam int            PHASE_ITEMS  = 275;
  localparam int            CYCLE_LIMIT  = 1000000;
  localparam logic [OP_W-1:0] OP_UNUSED  = 3'd7;

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode    = '0;
  logic [ID_W-1:0]   in_event_id  = '0;
  logic [SND_W-1:0]  in_sender_id = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic              out_hit;
  logic [SND_W-1:0]  out_last_sender;
  logic              out_sender_valid;
  logic              out_sender_match;
  logic [PCNT_W-1:0] out_pending_count;
  logic              out_generic_pending;
  logic              out_table_full;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int fail_count;
  int outstanding;

  event_subscription_table_top #(.SLOTS(SLOTS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_event_id         (in_event_id),
    .in_sender_id        (in_sender_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_last_sender     (out_last_sender),
    .out_sender_valid    (out_sender_valid),
    .out_sender_match    (out_sender_match),
    .out_pending_count   (out_pending_count),
    .out_generic_pending (out_generic_pending),
    .out_table_full      (out_table_full)
  );

  subscription_checker #(.SLOTS(SLOTS)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_event_id         (in_event_id),
    .in_sender_id        (in_sender_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_last_sender     (out_last_sender),
    .out_sender_valid    (out_sender_valid),
    .out_sender_match    (out_sender_match),
    .out_pending_count   (out_pending_count),
    .out_generic_pending (out_generic_pending),
    .out_table_full      (out_table_full),
    .fail_count          (fail_count),
    .outstanding         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [SND_W-1:0] snd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_event_id  <= id;
    in_sender_id <= snd;
    // hold the beat until it is taken
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [SND_W-1:0] snd;
    logic [ID_W-1:0]  id_pool [24];
    logic [SND_W-1:0] sender_set [4];
    int               pool_size;
    int               pick;

    sender_set[0] = 16'h0000;
    sender_set[1] = 16'hFFFF;
    sender_set[2] = 16'h5A5A;
    sender_set[3] = 16'hA5A5;
    pool_size     = 1;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_cmd(OP_IS_REG, LOS_ID, 16'h0000);
    send_cmd(OP_QUERY, LOS_ID, 16'hFFFF);
    send_cmd(OP_POST, LOS_ID, 16'hFFFF);
    send_cmd(OP_QUERY, LOS_ID, 16'hFFFF);
    send_cmd(OP_CHECK_CLEAR, LOS_ID, 16'h0000);
    send_cmd(OP_REGISTER, DELETED_ID, 16'h0000);
    send_cmd(OP_REGISTER, 8'hFF, 16'h0000);
    send_cmd(OP_REGISTER, 8'hFF, 16'hFFFF);
    send_cmd(OP_POST, LOS_ID, 16'h1234);
    send_cmd(OP_POST, 8'hFF, 16'h0000);
    send_cmd(OP_CHECK_CLEAR, 8'hFF, 16'h0000);
    send_cmd(OP_POST, LOS_ID, 16'hA5A5);
    send_cmd(OP_CHECK_CLEAR, DELETED_ID, 16'h0000);
    send_cmd(OP_POST, DELETED_ID, 16'hFFFF);
    send_cmd(OP_QUERY, DELETED_ID, 16'h0000);
    send_cmd(OP_IS_REG, DELETED_ID, 16'h0000);
    send_cmd(OP_REMOVE, DELETED_ID, 16'h0000);
    send_cmd(OP_UNUSED, 8'h55, 16'h5555);
    send_cmd(OP_POST, 8'hFF, 16'hFFFF);
    send_cmd(OP_REMOVE, 8'hFF, 16'h0000);
    send_cmd(OP_REMOVE, LOS_ID, 16'h0000);
    send_cmd(OP_REGISTER, 8'h02, 16'h0000);
    send_cmd(OP_REGISTER, 8'hFE, 16'h0000);
    send_cmd(OP_QUERY, 8'h02, 16'h0000);
    send_cmd(OP_CLEAR_ALL, 8'hAA, 16'hFFFF);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        case (n / PHASE_ITEMS)
          0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
          default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
      end
      // refresh the ID pool now and then
      if (n % 50 == 0) begin
        pool_size = $urandom_range(4, 24);
        for (int k = 0; k < pool_size; k++) begin
          pick = $urandom_range(99);
          if (pick < 70)      id_pool[k] = ID_W'($urandom_range(2, 30));
          else if (pick < 80) id_pool[k] = LOS_ID;
          else                id_pool[k] = ID_W'($urandom_range(0, 255));
        end
      end
      pick = $urandom_range(99);
      if (pick < 22)      op = OP_REGISTER;
      else if (pick < 32) op = OP_REMOVE;
      else if (pick < 52) op = OP_POST;
      else if (pick < 70) op = OP_CHECK_CLEAR;
      else if (pick < 73) op = OP_CLEAR_ALL;
      else if (pick < 84) op = OP_QUERY;
      else if (pick < 97) op = OP_IS_REG;
      else                op = OP_UNUSED;
      if ($urandom_range(99) < 88) id = id_pool[$urandom_range(0, pool_size - 1)];
      else                         id = ID_W'($urandom_range(0, 255));
      if ($urandom_range(1)) snd = sender_set[$urandom_range(0, 3)];
      else                   snd = SND_W'($urandom_range(0, 65535));
      send_cmd(op, id, snd);
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/est_pkg.sv
hw/rtl/est_ram.sv
hw/rtl/event_subscription_table_top.sv
bench/subscription_checker.sv
bench/event_subscription_table_top_tb.sv
